### hdl/uire_pkg.sv
// ----------------------------------------------------------------------------
// uire_pkg
// Shared types, codes and the key translation table for the USB input
// report to event converter.
// ----------------------------------------------------------------------------
`default_nettype none

package uire_pkg;

  // event kinds
  localparam logic [1:0] KIND_PRESS   = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_MOTION  = 2'd2;

  // report kinds
  localparam logic ACT_MOUSE = 1'b0;
  localparam logic ACT_KEY   = 1'b1;

  // event code used for the shift key
  localparam logic [8:0] SHIFT_CODE = 9'd42;

  // register indexes (paddr bit 2)
  localparam logic REG_LEFT  = 1'b0;
  localparam logic REG_RIGHT = 1'b1;

  localparam int unsigned CFG_AW = 3;
  localparam logic [8:0] LEFT_RESET  = 9'd272;
  localparam logic [8:0] RIGHT_RESET = 9'd273;

  // event slots of one run, emitted lowest first
  // mouse: left edge, right edge, motion
  // keyboard: shift press, key press, key release, shift release
  localparam logic [3:0] SLOT_0 = 4'b0001;
  localparam logic [3:0] SLOT_1 = 4'b0010;
  localparam logic [3:0] SLOT_2 = 4'b0100;
  localparam logic [3:0] SLOT_3 = 4'b1000;

  localparam logic [3:0] MASK_SHIFT_RUN = 4'b1111;
  localparam logic [3:0] MASK_KEY_RUN   = 4'b0110;

  // one report's run, as handed from the front end to the back end
  typedef struct packed {
    logic       is_key;
    logic [3:0] mask;
    logic [1:0] buttons;
    logic [7:0] key;
    logic [7:0] dx;
    logic [7:0] dy;
  } run_t;

  typedef struct packed {
    logic valid;
    run_t run;
  } push_t;

  // USB usage to set-1 scancode, 0xff where unmapped
  function automatic logic [7:0] key_xlate(input logic [7:0] usage);
    logic [7:0] code;
    case (usage)
      8'h04: code = 8'h1e;  8'h05: code = 8'h30;  8'h06: code = 8'h2e;
      8'h07: code = 8'h20;  8'h08: code = 8'h12;  8'h09: code = 8'h21;
      8'h0a: code = 8'h22;  8'h0b: code = 8'h23;  8'h0c: code = 8'h17;
      8'h0d: code = 8'h24;  8'h0e: code = 8'h25;  8'h0f: code = 8'h26;
      8'h10: code = 8'h32;  8'h11: code = 8'h31;  8'h12: code = 8'h18;
      8'h13: code = 8'h19;  8'h14: code = 8'h10;  8'h15: code = 8'h13;
      8'h16: code = 8'h1f;  8'h17: code = 8'h14;  8'h18: code = 8'h16;
      8'h19: code = 8'h2f;  8'h1a: code = 8'h11;  8'h1b: code = 8'h2d;
      8'h1c: code = 8'h15;  8'h1d: code = 8'h2c;  8'h1e: code = 8'h02;
      8'h1f: code = 8'h03;  8'h20: code = 8'h04;  8'h21: code = 8'h05;
      8'h22: code = 8'h06;  8'h23: code = 8'h07;  8'h24: code = 8'h08;
      8'h25: code = 8'h09;  8'h26: code = 8'h0a;  8'h27: code = 8'h0b;
      8'h28: code = 8'h1c;  8'h29: code = 8'h01;  8'h2a: code = 8'h0e;
      8'h2b: code = 8'h0f;  8'h2c: code = 8'h39;  8'h2e: code = 8'h2b;
      8'h2f: code = 8'h1a;  8'h30: code = 8'h1b;  8'h32: code = 8'h2b;
      8'h33: code = 8'h27;  8'h34: code = 8'h28;  8'h36: code = 8'h33;
      8'h37: code = 8'h34;  8'h38: code = 8'h35;  8'h54: code = 8'h62;
      8'h56: code = 8'h4a;  8'h58: code = 8'h60;  8'h59: code = 8'h4f;
      8'h5a: code = 8'h50;  8'h5b: code = 8'h51;  8'h5c: code = 8'h4b;
      8'h5d: code = 8'h4c;  8'h5e: code = 8'h4e;  8'h5f: code = 8'h47;
      8'h60: code = 8'h48;  8'h61: code = 8'h49;  8'h62: code = 8'h52;
      8'h63: code = 8'h53;  8'h64: code = 8'h56;  8'h67: code = 8'h49;
      default: code = 8'hff;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

### hdl/uire_if.sv
// ----------------------------------------------------------------------------
// uire_if
// Valid/ready channels for input reports and output events.
// ----------------------------------------------------------------------------
`default_nettype none

interface uire_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] report;
  modport source (output valid, action, report, input ready);
  modport sink   (input valid, action, report, output ready);
endinterface

interface uire_out_if;
  logic              valid;
  logic              ready;
  logic [1:0]        event_kind;
  logic [8:0]        event_code;
  logic signed [7:0] delta_x;
  logic signed [7:0] delta_y;
  logic              last;
  modport source (output valid, event_kind, event_code, delta_x, delta_y, last,
                  input ready);
  modport sink   (input valid, event_kind, event_code, delta_x, delta_y, last,
                  output ready);
endinterface

`default_nettype wire

### hdl/uire_front.sv
// ----------------------------------------------------------------------------
// uire_front
// Accepts reports, tracks mouse buttons and turns each report into a run
// descriptor for the queue. Quiet mouse reports push nothing.
// ----------------------------------------------------------------------------
`default_nettype none

module uire_front (
  input  wire logic            clk,
  input  wire logic            rst,
  uire_in_if.sink              rpt,
  input  wire logic            full,
  output uire_pkg::push_t      push
);

  logic [1:0] prev_buttons;
  logic [1:0] now;
  logic [1:0] changed;
  logic       motion;
  logic       shift;
  logic       accept;
  logic [3:0] mask;

  assign rpt.ready = !full;
  assign accept    = rpt.valid && !full;

  // classify
  assign now     = rpt.report[25:24];
  assign changed = now ^ prev_buttons;
  assign motion  = rpt.report[23:8] != 16'd0;
  assign shift   = rpt.report[25] | rpt.report[29];

  always_comb begin
    if (rpt.action == uire_pkg::ACT_KEY) begin
      mask = shift ? uire_pkg::MASK_SHIFT_RUN : uire_pkg::MASK_KEY_RUN;
    end else begin
      mask = {1'b0, motion, changed[1], changed[0]};
    end
  end

  assign push.valid       = accept && (mask != 4'd0);
  assign push.run.is_key  = rpt.action;
  assign push.run.mask    = mask;
  assign push.run.buttons = now;
  assign push.run.key     = uire_pkg::key_xlate(rpt.report[23:16]);
  assign push.run.dx      = rpt.report[23:16];
  assign push.run.dy      = rpt.report[15:8];

  // button history, mouse reports only
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_buttons <= 2'd0;
    end else if (accept && rpt.action == uire_pkg::ACT_MOUSE) begin
      prev_buttons <= now;
    end
  end

endmodule

`default_nettype wire

### hdl/uire_queue.sv
// ----------------------------------------------------------------------------
// uire_queue
// Two-entry run queue between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module uire_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire uire_pkg::push_t push,
  output logic                 full,
  output logic                 pop_valid,
  output uire_pkg::run_t       pop_run,
  input  wire logic            pop
);

  uire_pkg::run_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_pop;

  assign full      = count == 2'd2;
  assign pop_valid = count != 2'd0;
  assign pop_run   = mem[rd_ptr];
  assign do_pop    = pop && pop_valid;

  // storage
  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[wr_ptr] <= push.run;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push.valid) wr_ptr <= !wr_ptr;
      if (do_pop)     rd_ptr <= !rd_ptr;
      case ({push.valid, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

### hdl/uire_back.sv
// ----------------------------------------------------------------------------
// uire_back
// Walks the slot mask of one run, one event a beat, into the output
// register. The next run loads as the last event of the current one issues.
// ----------------------------------------------------------------------------
`default_nettype none

module uire_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic [8:0]      left_code,
  input  wire logic [8:0]      right_code,
  input  wire logic            pop_valid,
  input  wire uire_pkg::run_t  pop_run,
  output logic                 pop,
  uire_out_if.source           evt
);

  uire_pkg::run_t cur;
  logic [3:0] pending;
  logic [3:0] pending_after;
  logic [3:0] low;
  logic       busy;
  logic       adv;
  logic       emit;
  logic       out_valid;

  logic [1:0] slot_kind;
  logic [8:0] slot_code;
  logic       slot_motion;

  assign busy          = pending != 4'd0;
  assign adv           = !out_valid || evt.ready;
  assign emit          = busy && adv;
  assign low           = pending & (~pending + 4'd1);
  assign pending_after = emit ? (pending & ~low) : pending;
  assign pop           = pop_valid && (pending_after == 4'd0);

  // decode the current slot
  always_comb begin
    slot_kind   = uire_pkg::KIND_PRESS;
    slot_code   = 9'd0;
    slot_motion = 1'b0;
    if (cur.is_key) begin
      case (low)
        uire_pkg::SLOT_0: begin
          slot_code = uire_pkg::SHIFT_CODE;
        end
        uire_pkg::SLOT_1: begin
          slot_code = {1'b0, cur.key};
        end
        uire_pkg::SLOT_2: begin
          slot_kind = uire_pkg::KIND_RELEASE;
          slot_code = {1'b0, cur.key};
        end
        uire_pkg::SLOT_3: begin
          slot_kind = uire_pkg::KIND_RELEASE;
          slot_code = uire_pkg::SHIFT_CODE;
        end
        default: begin
          slot_code = 9'd0;
        end
      endcase
    end else begin
      case (low)
        uire_pkg::SLOT_0: begin
          slot_kind = cur.buttons[0] ? uire_pkg::KIND_PRESS : uire_pkg::KIND_RELEASE;
          slot_code = left_code;
        end
        uire_pkg::SLOT_1: begin
          slot_kind = cur.buttons[1] ? uire_pkg::KIND_PRESS : uire_pkg::KIND_RELEASE;
          slot_code = right_code;
        end
        uire_pkg::SLOT_2: begin
          slot_kind   = uire_pkg::KIND_MOTION;
          slot_motion = 1'b1;
        end
        default: begin
          slot_code = 9'd0;
        end
      endcase
    end
  end

  // run control
  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= 4'd0;
      out_valid <= 1'b0;
    end else begin
      pending <= pop ? pop_run.mask : pending_after;
      if (adv) out_valid <= busy;
    end
  end

  // run and event payload
  always_ff @(posedge clk) begin
    if (pop) cur <= pop_run;
    if (emit) begin
      evt.event_kind <= slot_kind;
      evt.event_code <= slot_code;
      evt.delta_x    <= slot_motion ? cur.dx : 8'd0;
      evt.delta_y    <= slot_motion ? cur.dy : 8'd0;
      evt.last       <= pending_after == 4'd0;
    end
  end

  assign evt.valid = out_valid;

endmodule

`default_nettype wire

### hdl/usb_input_report_to_events.sv
// ----------------------------------------------------------------------------
// usb_input_report_to_events
// Turns tagged USB mouse and keyboard input reports into press, release and
// motion events.
// ----------------------------------------------------------------------------
// A report is taken whenever the two-entry run queue has room, even while
// events wait at the output. A mouse report gives zero to three events, a
// keyboard report two or four; the back end issues one event per cycle from
// its output register while the output is ready, and loads the next run as
// the previous run's last event enters that register, so the output carries
// one event per cycle while it is ready. Between acceptance and the first
// event lie the queue entry, the back end's run register and the output
// register. Button codes are set through the APB port: left at 0x0, right at 0x4.
`default_nettype none

module usb_input_report_to_events (
  input  wire logic                          clk,
  input  wire logic                          rst,
  uire_in_if.sink                            rpt,
  uire_out_if.source                         evt,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [uire_pkg::CFG_AW-1:0]   paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  logic [8:0] left_code;
  logic [8:0] right_code;
  logic       cfg_wr;

  uire_pkg::push_t push;
  uire_pkg::run_t  pop_run;
  logic            full;
  logic            pop_valid;
  logic            pop;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_code  <= uire_pkg::LEFT_RESET;
      right_code <= uire_pkg::RIGHT_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == uire_pkg::REG_RIGHT) begin
        right_code <= pwdata[8:0];
      end else begin
        left_code <= pwdata[8:0];
      end
    end
  end

  assign prdata = (paddr[2] == uire_pkg::REG_RIGHT) ? {23'd0, right_code}
                                                    : {23'd0, left_code};

  uire_front u_front (
    .clk  (clk),
    .rst  (rst),
    .rpt  (rpt),
    .full (full),
    .push (push)
  );

  uire_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .pop_valid (pop_valid),
    .pop_run   (pop_run),
    .pop       (pop)
  );

  uire_back u_back (
    .clk        (clk),
    .rst        (rst),
    .left_code  (left_code),
    .right_code (right_code),
    .pop_valid  (pop_valid),
    .pop_run    (pop_run),
    .pop        (pop),
    .evt        (evt)
  );

endmodule

`default_nettype wire

### hdl/uire_checker.sv
// ----------------------------------------------------------------------------
// uire_checker
// Port-level checks on the event channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module uire_checker (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              evt_valid,
  input  wire logic              evt_ready,
  input  wire logic [1:0]        evt_kind,
  input  wire logic [8:0]        evt_code,
  input  wire logic [7:0]        evt_dx,
  input  wire logic [7:0]        evt_dy
);

  // no event right after reset
  a_idle_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !evt_valid)
    else $error("event valid right after reset");

  // a stalled beat stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    evt_valid && !evt_ready |=> evt_valid)
    else $error("event dropped while stalled");

  // motion events carry no code
  a_motion_code: assert property (@(posedge clk) disable iff (rst)
    evt_valid && evt_kind == uire_pkg::KIND_MOTION |-> evt_code == 9'd0)
    else $error("motion event with nonzero code");

  // key and button events carry no motion
  a_button_delta: assert property (@(posedge clk) disable iff (rst)
    evt_valid && evt_kind != uire_pkg::KIND_MOTION |->
      evt_dx == 8'd0 && evt_dy == 8'd0)
    else $error("press or release event with nonzero delta");

endmodule

bind usb_input_report_to_events uire_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .evt_valid (evt.valid),
  .evt_ready (evt.ready),
  .evt_kind  (evt.event_kind),
  .evt_code  (evt.event_code),
  .evt_dx    (evt.delta_x),
  .evt_dy    (evt.delta_y)
);

`default_nettype wire

### verif/tb_usb_input_report_to_events.sv
// ----------------------------------------------------------------------------
// tb_usb_input_report_to_events
// Self-checking bench for the USB report to event converter. Mouse and
// keyboard reports go in on a valid/ready channel. An in-bench predictor
// expands each accepted report into its expected events, and every event
// beat that comes out is checked against the oldest one still due. Button
// codes are set over APB between phases, once the block has gone quiet.
// ----------------------------------------------------------------------------
module tb_usb_input_report_to_events;
  timeunit 1ns;
  timeprecision 1ps;

  // one report as sent, one event as predicted
  typedef struct packed {
    logic        action;
    logic [31:0] report;
  } report_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [8:0] code;
    logic [7:0] dx;
    logic [7:0] dy;
    logic       last;
  } event_t;

  // USB usage to set-1 code for usages 0x00..0x6f; everything above is unmapped
  localparam bit [0:111][7:0] SET1_MAP = {
    128'hffffffff_1e302e20_12212223_17242526,
    128'h32311819_10131f14_162f112d_152c0203,
    128'h04050607_08090a0b_1c010e0f_39ff2b1a,
    128'h1bff2b27_28ff3334_35ffffff_ffffffff,
    128'hffffffff_ffffffff_ffffffff_ffffffff,
    128'hffffffff_62ff4aff_604f5051_4b4c4e47,
    128'h48495253_56ffff49_ffffffff_ffffffff
  };

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [uire_pkg::CFG_AW-1:0] paddr;
  logic [31:0] pwdata;
  wire  [31:0] prdata;
  wire         pready;

  uire_in_if  rpt_if ();
  uire_out_if evt_if ();

  usb_input_report_to_events u_top (
    .clk     (clk),
    .rst     (rst),
    .rpt     (rpt_if),
    .evt     (evt_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor state and scoreboard
  report_t    reports_todo [$];
  event_t     events_due [$];
  logic [1:0] held_buttons;
  logic [8:0] left_code;
  logic [8:0] right_code;
  int         mismatches;

  // stall control
  int      in_gap;
  int      out_stall;
  bit      in_burst;
  bit      out_burst;
  report_t next_report;
  event_t  due_event;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  task automatic note_mismatch(input string msg);
    if (mismatches < 40) $display("%0t ns: mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // expand one accepted report into the events it should cause
  task automatic expand_report(input logic act, input logic [31:0] rpt);
    event_t     run [4];
    int         n;
    logic [1:0] now;
    logic [1:0] flip;
    logic [7:0] usage;
    logic [8:0] key_code;
    logic       shifted;
    n = 0;
    for (int i = 0; i < 4; i++) run[i] = '0;
    if (act == uire_pkg::ACT_MOUSE) begin
      now  = rpt[25:24];
      flip = now ^ held_buttons;
      if (flip[0]) begin
        run[n].kind = now[0] ? uire_pkg::KIND_PRESS : uire_pkg::KIND_RELEASE;
        run[n].code = left_code;
        n++;
      end
      if (flip[1]) begin
        run[n].kind = now[1] ? uire_pkg::KIND_PRESS : uire_pkg::KIND_RELEASE;
        run[n].code = right_code;
        n++;
      end
      if (rpt[23:8] != 16'h0) begin
        run[n].kind = uire_pkg::KIND_MOTION;
        run[n].dx   = rpt[23:16];
        run[n].dy   = rpt[15:8];
        n++;
      end
      held_buttons = now;
    end else begin
      usage    = rpt[23:16];
      key_code = {1'b0, (usage < 8'd112) ? SET1_MAP[usage] : 8'hff};
      shifted  = rpt[25] | rpt[29];
      if (shifted) begin
        run[n].kind = uire_pkg::KIND_PRESS;
        run[n].code = uire_pkg::SHIFT_CODE;
        n++;
      end
      run[n].kind = uire_pkg::KIND_PRESS;
      run[n].code = key_code;
      n++;
      run[n].kind = uire_pkg::KIND_RELEASE;
      run[n].code = key_code;
      n++;
      if (shifted) begin
        run[n].kind = uire_pkg::KIND_RELEASE;
        run[n].code = uire_pkg::SHIFT_CODE;
        n++;
      end
    end
    if (n > 0) run[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) events_due.push_back(run[i]);
  endtask

  // report driver: one beat per queued report, random gap after each
  always @(posedge clk) begin
    if (rst) begin
      rpt_if.valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (rpt_if.valid && rpt_if.ready) expand_report(rpt_if.action, rpt_if.report);
      if (!rpt_if.valid || rpt_if.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          rpt_if.valid <= 1'b0;
        end else if (reports_todo.size() != 0) begin
          next_report = reports_todo.pop_front();
          rpt_if.valid  <= 1'b1;
          rpt_if.action <= next_report.action;
          rpt_if.report <= next_report.report;
          if ($urandom_range(0, 15) == 0) in_burst = !in_burst;
          in_gap = in_burst ? 0 : $urandom_range(0, 8);
        end else begin
          rpt_if.valid <= 1'b0;
        end
      end
    end
  end

  // event monitor: check each beat, then stall a random number of cycles
  always @(posedge clk) begin
    if (rst) begin
      evt_if.ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (evt_if.valid && evt_if.ready) begin
        if (events_due.size() == 0) begin
          note_mismatch($sformatf("event with nothing due: kind %0d code %0d",
                                  evt_if.event_kind, evt_if.event_code));
        end else begin
          due_event = events_due.pop_front();
          if (evt_if.event_kind !== due_event.kind)
            note_mismatch($sformatf("event_kind %0d, expected %0d",
                                    evt_if.event_kind, due_event.kind));
          if (evt_if.event_code !== due_event.code)
            note_mismatch($sformatf("event_code %0d, expected %0d",
                                    evt_if.event_code, due_event.code));
          if (evt_if.delta_x !== due_event.dx)
            note_mismatch($sformatf("delta_x %0d, expected %0d",
                                    evt_if.delta_x, $signed(due_event.dx)));
          if (evt_if.delta_y !== due_event.dy)
            note_mismatch($sformatf("delta_y %0d, expected %0d",
                                    evt_if.delta_y, $signed(due_event.dy)));
          if (evt_if.last !== due_event.last)
            note_mismatch($sformatf("last %0b, expected %0b",
                                    evt_if.last, due_event.last));
        end
        if ($urandom_range(0, 15) == 0) out_burst = !out_burst;
        out_stall = out_burst ? 0 : $urandom_range(0, 8);
      end
      if (out_stall > 0) begin
        out_stall--;
        evt_if.ready <= 1'b0;
      end else begin
        evt_if.ready <= 1'b1;
      end
    end
  end

  // APB write: setup cycle, then access cycle; upper data bits are noise
  task automatic write_code(input logic idx, input logic [8:0] val);
    logic [31:0] word;
    word      = $urandom;
    word[8:0] = val;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == uire_pkg::REG_LEFT) left_code = val;
    else right_code = val;
  endtask

  // wait until every report is in and every event is out, then settle
  task automatic wait_quiet();
    while (reports_todo.size() != 0 || rpt_if.valid || events_due.size() != 0)
      @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic send(input logic act, input logic [31:0] rpt);
    report_t r;
    r.action = act;
    r.report = rpt;
    reports_todo.push_back(r);
  endtask

  // random reports: mouse with frequent button edges, keys mostly mapped
  task automatic send_random(input int count);
    logic        act;
    logic [31:0] w;
    for (int i = 0; i < count; i++) begin
      w   = $urandom;
      act = 1'($urandom_range(0, 1));
      if (act == uire_pkg::ACT_MOUSE) begin
        if ($urandom_range(0, 3) == 0) w[23:8] = 16'h0;
      end else begin
        if ($urandom_range(0, 3) != 0) w[23:16] = 8'($urandom_range(0, 8'h6f));
        if ($urandom_range(0, 2) == 0) begin
          w[25] = 1'b0;
          w[29] = 1'b0;
        end
      end
      send(act, w);
    end
  endtask

  initial begin
    rst           = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    rpt_if.valid  = 1'b0;
    rpt_if.action = uire_pkg::ACT_MOUSE;
    rpt_if.report = '0;
    evt_if.ready  = 1'b0;
    held_buttons  = 2'b00;
    left_code     = uire_pkg::LEFT_RESET;
    right_code    = uire_pkg::RIGHT_RESET;
    mismatches    = 0;
    in_burst      = 1'b0;
    out_burst     = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed, reset button codes
    send(uire_pkg::ACT_MOUSE, 32'h0100_0000);  // left press
    send(uire_pkg::ACT_MOUSE, 32'h0300_0000);  // right press
    send(uire_pkg::ACT_KEY,   32'h0004_0000);  // plain key, buttons untouched
    send(uire_pkg::ACT_MOUSE, 32'h0300_0000);  // buttons held, no motion: quiet
    send(uire_pkg::ACT_MOUSE, 32'h007f_8000);  // both release, motion +127/-128
    send(uire_pkg::ACT_MOUSE, 32'h0000_0000);  // quiet
    send(uire_pkg::ACT_MOUSE, 32'hfc00_00ff);  // only ignored bits set: quiet
    send(uire_pkg::ACT_MOUSE, 32'h0080_0000);  // dx only
    send(uire_pkg::ACT_MOUSE, 32'h0000_ff00);  // dy only
    send(uire_pkg::ACT_MOUSE, 32'hffff_ffff);  // both press, motion -1/-1
    send(uire_pkg::ACT_MOUSE, 32'h0201_0100);  // left release plus motion
    send(uire_pkg::ACT_KEY,   32'h0204_0000);  // shift from the low shift bit
    send(uire_pkg::ACT_KEY,   32'h2004_0000);  // shift from the high shift bit
    send(uire_pkg::ACT_KEY,   32'hdd1d_0000);  // other modifiers only, no shift
    send(uire_pkg::ACT_KEY,   32'h0000_0000);  // unmapped usage zero
    send(uire_pkg::ACT_KEY,   32'hffff_ffff);  // shifted, top usage unmapped
    send(uire_pkg::ACT_KEY,   32'h002d_0000);  // hole inside the mapped range
    send(uire_pkg::ACT_KEY,   32'h2267_0000);  // both shift bits, last mapped usage
    send(uire_pkg::ACT_KEY,   32'h0068_ffff);  // first unmapped above, low bits ignored
    send(uire_pkg::ACT_KEY,   32'h0038_0000);
    send(uire_pkg::ACT_MOUSE, 32'h0000_0000);  // right release
    wait_quiet();

    // random phases over several button code settings
    write_code(uire_pkg::REG_LEFT, 9'd0);
    write_code(uire_pkg::REG_RIGHT, 9'd511);
    send_random(50);
    wait_quiet();

    write_code(uire_pkg::REG_LEFT, 9'd511);
    write_code(uire_pkg::REG_RIGHT, 9'd0);
    send_random(50);
    wait_quiet();

    write_code(uire_pkg::REG_LEFT, 9'($urandom));
    write_code(uire_pkg::REG_RIGHT, 9'($urandom));
    send_random(50);
    wait_quiet();

    write_code(uire_pkg::REG_RIGHT, uire_pkg::LEFT_RESET);
    write_code(uire_pkg::REG_LEFT, uire_pkg::RIGHT_RESET);
    send_random(50);
    wait_quiet();

    if (events_due.size() != 0)
      note_mismatch($sformatf("%0d events never arrived", events_due.size()));
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // hard limit on run time
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
